>>> rtl/core/pszs_pkg.sv
// pszs_pkg: shared constants and types for the pair spread z-score block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pszs_pkg;
  localparam int unsigned MaxWindow = 256;
  localparam int unsigned ZW        = 24;
  localparam int unsigned NumW      = 34;   // |W*x - S| < 2^33
  localparam int unsigned DevW      = 66;   // W*Q - S*S

  localparam logic [1:0] CfgHedge = 2'd0;
  localparam logic [1:0] CfgEntry = 2'd1;
  localparam logic [1:0] CfgExit  = 2'd2;
  localparam logic [1:0] CfgWin   = 2'd3;

  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActShort = 2'd1;
  localparam logic [1:0] ActLong  = 2'd2;
  localparam logic [1:0] ActExit  = 2'd3;

  typedef struct packed {
    logic                    start;
    logic                    neg;
    logic [NumW-1:0]         n_abs;
    logic [DevW-1:0]         dev;
  } zs_req_t;
endpackage
`default_nettype wire

>>> rtl/core/pszs_zdiv.sv
// pszs_zdiv: bit-serial search for z = round(2^16 * |n| / sqrt(d)).
// Depends on pszs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pszs_zdiv (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire pszs_pkg::zs_req_t       req_i,
  output logic                         done_o,
  output logic [pszs_pkg::ZW-1:0]      z_o
);
  // t = largest value with d*t^2 <= n^2 * 2^34, one bit per cycle;
  // d*t and d*t^2 are tracked so a trial needs only shifts and adds
  logic [30:0]  t_q, t_d;
  logic [4:0]   bit_q, bit_d;
  logic         busy_q, busy_d, done_q, done_d;
  logic [127:0] dt_q, dt_d, dtt_q, dtt_d;
  logic         neg_q;
  logic [127:0] tgt_q;
  logic [pszs_pkg::DevW-1:0] dev_q;
  logic [127:0] dev_w;
  logic [127:0] trial;
  logic [31:0]  qr;
  logic [pszs_pkg::ZW-1:0] zq;

  always_comb begin
    dev_w = {62'd0, dev_q};
    trial = dtt_q + (dt_q << ({1'b0, bit_q} + 6'd1)) + (dev_w << {bit_q, 1'b0});
    t_d = t_q; bit_d = bit_q; busy_d = busy_q; done_d = 1'b0;
    dt_d = dt_q; dtt_d = dtt_q;
    if (req_i.start) begin
      t_d = '0; bit_d = 5'd30; busy_d = 1'b1; dt_d = '0; dtt_d = '0;
    end else if (busy_q) begin
      if (trial <= tgt_q) begin
        t_d   = t_q | (31'd1 << bit_q);
        dt_d  = dt_q + (dev_w << bit_q);
        dtt_d = trial;
      end
      if (bit_q == 5'd0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end else begin
        bit_d = bit_q - 5'd1;
      end
    end
    qr = ({1'b0, t_q} + 32'd1) >> 1;
    if (neg_q) begin
      zq = (qr > 32'd8388608) ? 24'h800000 : 24'(-qr);
    end else begin
      zq = (qr > 32'd8388607) ? 24'h7FFFFF : qr[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= '0; bit_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
      dt_q <= '0; dtt_q <= '0;
    end else begin
      t_q <= t_d; bit_q <= bit_d; busy_q <= busy_d; done_q <= done_d;
      dt_q <= dt_d; dtt_q <= dtt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.neg;
      dev_q <= req_i.dev;
      tgt_q <= {26'd0, 68'({34'd0, req_i.n_abs} * {34'd0, req_i.n_abs}), 34'd0};
    end
  end

  assign done_o = done_q;
  assign z_o    = zq;
endmodule
`default_nettype wire

>>> rtl/core/pair_spread_zscore_signal.sv
// pair_spread_zscore_signal: top level, spread ring memory, running sums, action.
// Depends on pszs_pkg and pszs_zdiv.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted price pair yields one word. On accept the spread is written to a
// synchronous ring memory while the entry it replaces is read; the running sums
// update next, then W*Q and S*S are formed and compared. While the window is not
// full, or W*Q does not exceed S*S, the word then passes the action and output
// states. With a full window the z-score search first resolves one bit per cycle
// over 31 bits. One item is in flight at a time and the input is ready again in
// the cycle the word turns valid. A word waiting in the output register does not
// block the input; the next item stalls before its result stage until that word
// is taken.
module pair_spread_zscore_signal (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] price_a_i,
  input  wire logic [31:0] price_b_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [23:0]      z_score_o,
  output logic [1:0]       action_o,
  output logic             window_full_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam int unsigned AW =
      (pszs_pkg::MaxWindow > 1) ? $clog2(pszs_pkg::MaxWindow) : 1;
  localparam int unsigned CW = $clog2(pszs_pkg::MaxWindow + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StDev  = 3'd3;
  localparam logic [2:0] StZ    = 3'd4;
  localparam logic [2:0] StAct  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;
  localparam logic [2:0] StChk  = 3'd7;

  logic [2:0]  st_q, st_d;
  logic signed [23:0] hedge_q;
  logic [23:0] entry_q, exit_q;
  logic [8:0]  win_q;
  logic [AW-1:0] slot_q;
  logic [CW-1:0] fill_q;
  logic signed [31:0] sum_q;
  logic signed [55:0] sq_q;
  logic signed [23:0] ring [pszs_pkg::MaxWindow];
  logic signed [23:0] old_q, s_q;
  logic [AW-1:0] wslot;
  logic [CW-1:0] weff;
  logic          was_full_q, full_q;
  logic signed [65:0] wq_q, ss_q;
  logic signed [34:0] num_q;
  logic signed [23:0] z_q;
  logic [23:0] zout_q;
  logic [1:0]  act_q;
  logic        wfull_q, ovalid_q;
  logic        dev_pos;
  logic        act_go;
  pszs_pkg::zs_req_t req;
  logic        zdone;
  logic [23:0] zres;

  logic signed [64:0] diff;
  logic signed [64:0] rnd;
  logic signed [44:0] sh;
  logic signed [23:0] sat;

  always_comb begin
    if (win_q < 9'd2) weff = CW'(2);
    else if ({23'd0, win_q} > pszs_pkg::MaxWindow) weff = CW'(pszs_pkg::MaxWindow);
    else weff = CW'(win_q);
    wslot = ({{(32-AW){1'b0}}, slot_q} >= 32'(weff)) ? '0 : slot_q;
    diff = $signed({1'b0, price_a_i, 16'd0}) - 65'(hedge_q * $signed({1'b0, price_b_i}));
    rnd  = diff + 65'sd524288;
    sh   = 45'(rnd >>> 20);
    if (sh > 45'sd8388607) sat = 24'sh7FFFFF;
    else if (sh < -45'sd8388608) sat = 24'sh800000;
    else sat = sh[23:0];
  end

  logic in_acc;
  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (st_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign act_go      = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring[wslot] <= sat;
      old_q <= ring[wslot];
      s_q <= sat;
    end
  end

  always_comb begin
    dev_pos   = wq_q > ss_q;
    req.start = (st_q == StChk) && full_q && dev_pos;
    req.neg   = num_q < 0;
    req.n_abs = 34'(num_q < 0 ? -num_q : num_q);
    req.dev   = 66'(wq_q - ss_q);
  end

  pszs_zdiv u_zdiv (.clk_i, .rst_ni, .req_i(req), .done_o(zdone), .z_o(zres));

  logic signed [31:0] sum_n;
  logic signed [55:0] sq_n;
  logic signed [31:0] sabs;
  always_comb begin
    sum_n = sum_q + 32'(s_q) - (was_full_q ? 32'(old_q) : 32'sd0);
    sq_n  = sq_q + 56'(s_q * s_q) - (was_full_q ? 56'(old_q * old_q) : 56'sd0);
    sabs  = sum_q < 0 ? -sum_q : sum_q;
    st_d = st_q;
    case (st_q)
      StIdle: if (in_acc) st_d = StRead;
      StRead: st_d = StSum;
      StSum:  st_d = StDev;
      StDev:  st_d = StChk;
      StChk:  st_d = req.start ? StZ : StAct;
      StZ:    if (zdone) st_d = StAct;
      StAct:  if (act_go) st_d = StOut;
      StOut:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; hedge_q <= 24'sd65536; entry_q <= 24'd131072;
      exit_q <= 24'd32768; win_q <= 9'd20; slot_q <= '0; fill_q <= '0;
      sum_q <= '0; sq_q <= '0; ovalid_q <= 1'b0;
      was_full_q <= 1'b0; full_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pszs_pkg::CfgHedge: hedge_q <= cfg_data_i[23:0];
          pszs_pkg::CfgEntry: entry_q <= cfg_data_i[23:0];
          pszs_pkg::CfgExit:  exit_q  <= cfg_data_i[23:0];
          pszs_pkg::CfgWin: begin
            win_q <= cfg_data_i[8:0]; slot_q <= '0; fill_q <= '0;
            sum_q <= '0; sq_q <= '0;
          end
          default: ;
        endcase
      end
      if (in_acc) begin
        was_full_q <= fill_q >= weff;
        if (fill_q < weff) fill_q <= fill_q + CW'(1);
        slot_q <= ({{(32-AW){1'b0}}, wslot} + 32'd1 >= 32'(weff)) ? '0 : wslot + AW'(1);
      end
      if (st_q == StSum) begin
        sum_q <= sum_n; sq_q <= sq_n; full_q <= fill_q >= weff;
      end
      if (st_q == StOut) ovalid_q <= 1'b1;
      else if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StSum) begin
      num_q <= 35'($signed({1'b0, 32'(weff)}) * 35'(s_q)) - 35'(sum_n);
    end
    if (st_q == StRead) begin
      wq_q <= '0; ss_q <= '0;
    end
    if (st_q == StDev) begin
      wq_q <= 66'($signed({1'b0, 32'(weff)}) * sq_q);
      ss_q <= 66'(sabs * sabs);
    end
    if (st_q == StDev) z_q <= '0;
    if (st_q == StZ && zdone) z_q <= zres;
    if (st_q == StAct && act_go) begin
      zout_q  <= z_q;
      wfull_q <= full_q;
      if (z_q > $signed({1'b0, entry_q})) act_q <= pszs_pkg::ActShort;
      else if (25'(z_q) < -$signed({1'b0, entry_q})) act_q <= pszs_pkg::ActLong;
      else if ((z_q < 0 ? -25'(z_q) : 25'(z_q)) < $signed({1'b0, exit_q}))
        act_q <= pszs_pkg::ActExit;
      else act_q <= pszs_pkg::ActNone;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign z_score_o     = zout_q;
  assign action_o      = act_q;
  assign window_full_o = wfull_q;
endmodule
`default_nettype wire
